// ===== src/rrbm_pkg.sv =====
// ----------------------------------------------------------------------------
// rrbm_pkg: bank-switching mapper shared definitions
// Item kinds, address regions, controller states and the command and status
// words passed between controller and datapath.
// ----------------------------------------------------------------------------
package rrbm_pkg;

  localparam int ROM_BANKS_DEF  = 128;
  localparam int RAM_BANKS_DEF  = 4;
  localparam int ROM_BANK_AW    = 14;   // 16 KiB per ROM bank
  localparam int RAM_BANK_AW    = 13;   // 8 KiB per RAM bank
  localparam int SEL_ROM_W      = 7;    // ROM bank select register
  localparam int SEL_RAM_W      = 2;    // RAM bank select register
  localparam int LOAD_W         = 21;
  localparam logic [SEL_ROM_W-1:0] ROM_SEL_RESET = SEL_ROM_W'(1);

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_LOAD  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // Bus address decoded on bits 15..13 (8 KiB regions)
  typedef enum logic [2:0] {
    RGN_CTL_ENABLE  = 3'd0,
    RGN_CTL_ROM_LO  = 3'd1,
    RGN_CTL_BANK_HI = 3'd2,
    RGN_CTL_MODE    = 3'd3,
    RGN_UNMAP_LO    = 3'd4,
    RGN_EXT_RAM     = 3'd5,
    RGN_UNMAP_HI0   = 3'd6,
    RGN_UNMAP_HI1   = 3'd7
  } region_t;

  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_ROM  = 2'd1,
    SRC_RAM  = 2'd2
  } src_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_FETCH = 1'b1
  } state_t;

  typedef struct packed {
    logic take;   // input word accepted this cycle
    logic emit;   // load the output register
  } cmd_t;

  typedef struct packed {
    logic is_read;
  } status_t;

endpackage

// ===== src/rrbm_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrbm_ctrl: mapper controller
// Sequences one bus read through the memory fetch and into the output
// register; writes and loads complete in the cycle they are accepted.
// ----------------------------------------------------------------------------
module rrbm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  rrbm_pkg::status_t status,
  output rrbm_pkg::cmd_t    cmd
);

  rrbm_pkg::state_t state;
  rrbm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrbm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rrbm_pkg::ST_IDLE: begin
        if (cmd.take && status.is_read) state_next = rrbm_pkg::ST_FETCH;
      end
      rrbm_pkg::ST_FETCH: begin
        if (cmd.emit) state_next = rrbm_pkg::ST_IDLE;
      end
      default: state_next = rrbm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.take = 1'b0;
    cmd.emit = 1'b0;
    case (state)
      rrbm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      rrbm_pkg::ST_FETCH: begin
        // hold the fetched word until the output register frees up
        cmd.emit = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== src/rrbm_datapath.sv =====
// ----------------------------------------------------------------------------
// rrbm_datapath: mapper registers, ROM and RAM arrays, read data path
// Decodes bus writes into the bank registers, stores ROM image and RAM
// bytes, and fetches and selects the byte returned by a bus read.
// ----------------------------------------------------------------------------
module rrbm_datapath #(
  parameter int ROM_BANKS = rrbm_pkg::ROM_BANKS_DEF,
  parameter int RAM_BANKS = rrbm_pkg::RAM_BANKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [1:0]                  kind,
  input  logic [15:0]                 bus_address,
  input  logic [rrbm_pkg::LOAD_W-1:0] load_index,
  input  logic [7:0]                  data_in,
  output logic [7:0]                  read_data,
  input  rrbm_pkg::cmd_t              cmd,
  output rrbm_pkg::status_t           status
);

  localparam int ROM_BW    = $clog2(ROM_BANKS);
  localparam int RAM_BW    = (RAM_BANKS > 1) ? $clog2(RAM_BANKS) : 1;
  localparam int ROM_AW    = ROM_BW + rrbm_pkg::ROM_BANK_AW;
  localparam int RAM_AW    = RAM_BW + rrbm_pkg::RAM_BANK_AW;
  localparam int ROM_DEPTH = ROM_BANKS * (1 << rrbm_pkg::ROM_BANK_AW);
  localparam int RAM_DEPTH = RAM_BANKS * (1 << rrbm_pkg::RAM_BANK_AW);
  localparam logic [rrbm_pkg::LOAD_W:0] ROM_LIMIT = (rrbm_pkg::LOAD_W + 1)'(ROM_DEPTH);
  localparam int ROM_SEL_N = 1 << rrbm_pkg::SEL_ROM_W;
  localparam int RAM_SEL_N = 1 << rrbm_pkg::SEL_RAM_W;

  logic [rrbm_pkg::SEL_ROM_W-1:0] rom_bank_select;
  logic [rrbm_pkg::SEL_RAM_W-1:0] ram_bank_select;
  logic                           ram_access_enabled;
  logic                           ram_mode_selected;

  logic [7:0] rom_mem [ROM_DEPTH];
  logic [7:0] ram_mem [RAM_DEPTH];
  logic [7:0] rom_q;
  logic [7:0] ram_q;
  rrbm_pkg::src_t src;

  // bank select reduced to the fitted bank count
  logic [ROM_BW-1:0] rom_mod_lut [ROM_SEL_N];
  logic [RAM_BW-1:0] ram_mod_lut [RAM_SEL_N];

  for (genvar g = 0; g < ROM_SEL_N; g++) begin : g_rom_lut
    assign rom_mod_lut[g] = ROM_BW'(g % ROM_BANKS);
  end
  for (genvar g = 0; g < RAM_SEL_N; g++) begin : g_ram_lut
    assign ram_mod_lut[g] = RAM_BW'(g % RAM_BANKS);
  end

  rrbm_pkg::region_t region;
  logic              is_write;
  logic              is_load;
  logic [4:0]        rom_low;
  logic [ROM_AW-1:0] rom_raddr;
  logic [RAM_AW-1:0] ram_addr;
  logic              load_in_range;

  assign region        = rrbm_pkg::region_t'(bus_address[15:13]);
  assign status.is_read = (kind == rrbm_pkg::KIND_READ);
  assign is_write      = cmd.take && (kind == rrbm_pkg::KIND_WRITE);
  assign is_load       = cmd.take && (kind == rrbm_pkg::KIND_LOAD);
  assign rom_low       = (data_in[4:0] == 5'd0) ? 5'd1 : data_in[4:0];
  assign load_in_range = {1'b0, load_index} < ROM_LIMIT;

  // bank 0 is fixed below 0x4000; above it the selected bank is used
  assign rom_raddr = bus_address[14] ?
                     {rom_mod_lut[rom_bank_select], bus_address[13:0]} :
                     {{ROM_BW{1'b0}}, bus_address[13:0]};
  assign ram_addr  = {ram_mod_lut[ram_bank_select], bus_address[12:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank_select    <= rrbm_pkg::ROM_SEL_RESET;
      ram_bank_select    <= '0;
      ram_access_enabled <= 1'b0;
      ram_mode_selected  <= 1'b0;
    end else if (is_write) begin
      case (region)
        rrbm_pkg::RGN_CTL_ENABLE: ram_access_enabled <= (data_in[3:0] == 4'hA);
        rrbm_pkg::RGN_CTL_ROM_LO: rom_bank_select[4:0] <= rom_low;
        rrbm_pkg::RGN_CTL_BANK_HI: begin
          if (ram_mode_selected) ram_bank_select <= data_in[1:0];
          else rom_bank_select[6:5] <= data_in[1:0];
        end
        rrbm_pkg::RGN_CTL_MODE: ram_mode_selected <= (data_in != 8'd0);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (is_load && load_in_range) begin
      rom_mem[load_index[ROM_AW-1:0]] <= data_in;
    end
    if (cmd.take && status.is_read) begin
      rom_q <= rom_mem[rom_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (is_write && (region == rrbm_pkg::RGN_EXT_RAM)) begin
      ram_mem[ram_addr] <= data_in;
    end
    if (cmd.take && status.is_read) begin
      ram_q <= ram_mem[ram_addr];
    end
  end

  // pick the byte source when the read is taken, with RAM gated by enable
  always_ff @(posedge clk) begin
    if (cmd.take && status.is_read) begin
      case (region)
        rrbm_pkg::RGN_CTL_ENABLE,
        rrbm_pkg::RGN_CTL_ROM_LO,
        rrbm_pkg::RGN_CTL_BANK_HI,
        rrbm_pkg::RGN_CTL_MODE: src <= rrbm_pkg::SRC_ROM;
        rrbm_pkg::RGN_EXT_RAM: src <= ram_access_enabled ? rrbm_pkg::SRC_RAM :
                                                           rrbm_pkg::SRC_ZERO;
        default: src <= rrbm_pkg::SRC_ZERO;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (src)
        rrbm_pkg::SRC_ROM: read_data <= rom_q;
        rrbm_pkg::SRC_RAM: read_data <= ram_q;
        default:           read_data <= 8'd0;
      endcase
    end
  end

endmodule

// ===== src/rom_ram_bank_switch_mapper_top.sv =====
// ----------------------------------------------------------------------------
// rom_ram_bank_switch_mapper_top: cartridge ROM/RAM bank-switching mapper
// Takes ROM image loads, bus reads and bus writes; returns a byte per read.
// ----------------------------------------------------------------------------
// Read path: a bus read's byte passes the registered ROM/RAM array read and then
//   the output register, which it enters once an earlier byte has left.
// Input: writes and loads leave the input ready for the next word; a read holds
//   the input off for its fetch and while an earlier byte waits at the output.
// Reset clears the bank registers (ROM bank 1, RAM bank 0, RAM disabled,
//   ROM banking mode); ROM and RAM contents are kept.
module rom_ram_bank_switch_mapper_top #(
  parameter int ROM_BANKS = rrbm_pkg::ROM_BANKS_DEF,
  parameter int RAM_BANKS = rrbm_pkg::RAM_BANKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  kind,
  input  logic [15:0]                 bus_address,
  input  logic [rrbm_pkg::LOAD_W-1:0] load_index,
  input  logic [7:0]                  data_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  read_data
);

  rrbm_pkg::cmd_t    cmd;
  rrbm_pkg::status_t status;

  rrbm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rrbm_datapath #(
    .ROM_BANKS(ROM_BANKS),
    .RAM_BANKS(RAM_BANKS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .kind       (kind),
    .bus_address(bus_address),
    .load_index (load_index),
    .data_in    (data_in),
    .read_data  (read_data),
    .cmd        (cmd),
    .status     (status)
  );

  // a read blocks the input while its byte is fetched
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (kind == rrbm_pkg::KIND_READ)) |=> !in_ready)
    else $error("input not held during read fetch");

  // writes, loads and unused kinds leave the input ready for the next word
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (kind != rrbm_pkg::KIND_READ)) |=> in_ready)
    else $error("non-read word stalled the input");

  // a read taken with the output empty presents its byte after the array read and output register
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (kind == rrbm_pkg::KIND_READ) && !out_valid)
      |-> ##2 out_valid)
    else $error("read byte not presented on time");

endmodule

// ===== tb/rrbm_bank_checker.sv =====
// ----------------------------------------------------------------------------
// rrbm_bank_checker: scoreboard for the bank-switching mapper
// Watches both channels and tracks the bank registers and the ROM and RAM
// contents. It predicts the byte for each bus read and compares every
// returned byte with the oldest read still outstanding.
// ----------------------------------------------------------------------------
module rrbm_bank_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [15:0] bus_address,
  input  logic [20:0] load_index,
  input  logic [7:0]  data_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  read_data,
  output int          mismatches,
  output int          pending_reads,
  output int          bytes_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] RAM_KEY = 4'hA;

  logic [7:0]                     rom_image [int];
  logic [7:0]                     ram_image [int];
  logic [rrbm_pkg::SEL_ROM_W-1:0] rom_sel;
  logic [rrbm_pkg::SEL_RAM_W-1:0] ram_sel;
  logic                           ram_on;
  logic                           ram_mode;
  logic [7:0]                     read_q [$];
  logic [7:0]                     want;

  function automatic int ram_slot(input logic [15:0] a);
    return (int'(ram_sel) % rrbm_pkg::RAM_BANKS_DEF) * (1 << rrbm_pkg::RAM_BANK_AW)
           + int'(a[rrbm_pkg::RAM_BANK_AW-1:0]);
  endfunction

  function automatic logic [7:0] bus_byte(input logic [15:0] a);
    int slot;
    case (rrbm_pkg::region_t'(a[15:13]))
      rrbm_pkg::RGN_CTL_ENABLE, rrbm_pkg::RGN_CTL_ROM_LO: begin
        slot = int'(a[rrbm_pkg::ROM_BANK_AW-1:0]);
        return rom_image.exists(slot) ? rom_image[slot] : 8'h00;
      end
      rrbm_pkg::RGN_CTL_BANK_HI, rrbm_pkg::RGN_CTL_MODE: begin
        slot = (int'(rom_sel) % rrbm_pkg::ROM_BANKS_DEF) * (1 << rrbm_pkg::ROM_BANK_AW)
               + int'(a[rrbm_pkg::ROM_BANK_AW-1:0]);
        return rom_image.exists(slot) ? rom_image[slot] : 8'h00;
      end
      rrbm_pkg::RGN_EXT_RAM: begin
        if (!ram_on) return 8'h00;
        slot = ram_slot(a);
        return ram_image.exists(slot) ? ram_image[slot] : 8'h00;
      end
      default: return 8'h00;
    endcase
  endfunction

  task automatic bus_store(input logic [15:0] a, input logic [7:0] d);
    case (rrbm_pkg::region_t'(a[15:13]))
      rrbm_pkg::RGN_CTL_ENABLE:  ram_on = (d[3:0] == RAM_KEY);
      rrbm_pkg::RGN_CTL_ROM_LO:  rom_sel[4:0] = (d[4:0] == 5'd0) ? 5'd1 : d[4:0];
      rrbm_pkg::RGN_CTL_BANK_HI: begin
        // the two bits steer to the RAM bank or the ROM bank top by mode
        if (ram_mode) ram_sel = d[1:0];
        else rom_sel[6:5] = d[1:0];
      end
      rrbm_pkg::RGN_CTL_MODE:    ram_mode = (d != 8'h00);
      rrbm_pkg::RGN_EXT_RAM:     ram_image[ram_slot(a)] = d;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rom_sel  = rrbm_pkg::ROM_SEL_RESET;
      ram_sel  = '0;
      ram_on   = 1'b0;
      ram_mode = 1'b0;
      read_q.delete();
    end else begin
      // retire before taking a new word; a read never returns in its own cycle
      if (out_valid && out_ready) begin
        if (read_q.size() == 0) begin
          mismatches++;
          $display("%0t ns: read_data expected none, got 0x%02h", $time, read_data);
        end else begin
          want = read_q.pop_front();
          bytes_checked++;
          if (read_data !== want) begin
            mismatches++;
            $display("%0t ns: read_data expected 0x%02h, got 0x%02h", $time, want,
                     read_data);
          end
        end
      end
      if (in_valid && in_ready) begin
        case (rrbm_pkg::kind_t'(kind))
          rrbm_pkg::KIND_READ:  read_q.push_back(bus_byte(bus_address));
          rrbm_pkg::KIND_WRITE: bus_store(bus_address, data_in);
          rrbm_pkg::KIND_LOAD:  rom_image[int'(load_index)] = data_in;
          default: ;
        endcase
      end
    end
    pending_reads = read_q.size();
  end

endmodule

// ===== tb/rom_ram_bank_switch_mapper_top_test.sv =====
// ----------------------------------------------------------------------------
// rom_ram_bank_switch_mapper_top_test: bank-switching mapper testbench
// Loads a few bytes of every ROM bank and RAM bank, runs a directed sweep of
// the decode corners, then random reads, writes and loads under four mixes
// of sender idling and receiver stalls. Reads hit stored or unmapped space.
// ----------------------------------------------------------------------------
module rom_ram_bank_switch_mapper_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORDS_PER_PHASE = 325;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  kind;
  logic [15:0] bus_address;
  logic [20:0] load_index;
  logic [7:0]  data_in;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  read_data;

  int idle_pct;
  int stall_pct;
  int mismatches;
  int pending_reads;
  int bytes_checked;
  int n_reads, n_writes, n_loads, n_noops;

  // the only offsets ever read back, so no read hits an unwritten byte
  logic [rrbm_pkg::ROM_BANK_AW-1:0] rom_off [4];
  logic [rrbm_pkg::RAM_BANK_AW-1:0] ram_off [4];

  rom_ram_bank_switch_mapper_top uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .bus_address (bus_address),
    .load_index  (load_index),
    .data_in     (data_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_data   (read_data)
  );

  rrbm_bank_checker scoreboard (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .bus_address   (bus_address),
    .load_index    (load_index),
    .data_in       (data_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .read_data     (read_data),
    .mismatches    (mismatches),
    .pending_reads (pending_reads),
    .bytes_checked (bytes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input rrbm_pkg::kind_t k, input logic [15:0] a,
                           input logic [20:0] li, input logic [7:0] d);
    logic took;
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    kind        = k;
    bus_address = a;
    load_index  = li;
    data_in     = d;
    took        = 1'b0;
    while (!took) begin
      @(posedge clk);
      took = in_ready;
      @(negedge clk);
    end
    case (k)
      rrbm_pkg::KIND_READ:  n_reads++;
      rrbm_pkg::KIND_WRITE: n_writes++;
      rrbm_pkg::KIND_LOAD:  n_loads++;
      default:              n_noops++;
    endcase
  endtask

  task automatic bus_rd(input logic [15:0] a);
    send_word(rrbm_pkg::KIND_READ, a, 21'($urandom), 8'($urandom));
  endtask

  task automatic bus_wr(input logic [15:0] a, input logic [7:0] d);
    send_word(rrbm_pkg::KIND_WRITE, a, 21'($urandom), d);
  endtask

  task automatic rom_load(input logic [20:0] li, input logic [7:0] d);
    send_word(rrbm_pkg::KIND_LOAD, 16'($urandom), li, d);
  endtask

  // hold the sender until every read has returned
  task automatic drain_reads();
    in_valid = 1'b0;
    while (pending_reads != 0) @(negedge clk);
  endtask

  function automatic rrbm_pkg::region_t unmapped_region();
    case ($urandom_range(2))
      0:       return rrbm_pkg::RGN_UNMAP_LO;
      1:       return rrbm_pkg::RGN_UNMAP_HI0;
      default: return rrbm_pkg::RGN_UNMAP_HI1;
    endcase
  endfunction

  task automatic random_word();
    int                pick;
    rrbm_pkg::region_t rgn;
    logic [7:0]        d;
    pick = $urandom_range(99);
    d    = 8'($urandom);
    if (pick < 38) begin
      case ($urandom_range(3))
        0: bus_rd({2'b00, rom_off[$urandom_range(3)]});
        1: bus_rd({2'b01, rom_off[$urandom_range(3)]});
        2: bus_rd({rrbm_pkg::RGN_EXT_RAM, ram_off[$urandom_range(3)]});
        default: bus_rd({unmapped_region(), 13'($urandom)});
      endcase
    end else if (pick < 76) begin
      case ($urandom_range(5))
        0: begin
          rgn = rrbm_pkg::RGN_CTL_ENABLE;
          // mostly the enable key, so RAM reads see real data
          if ($urandom_range(9) < 7) d[3:0] = 4'hA;
        end
        1: begin
          rgn = rrbm_pkg::RGN_CTL_ROM_LO;
          if ($urandom_range(7) == 0) d[4:0] = 5'd0;
        end
        2: rgn = rrbm_pkg::RGN_CTL_BANK_HI;
        3: begin
          rgn = rrbm_pkg::RGN_CTL_MODE;
          if ($urandom_range(1) == 0) d = 8'h00;
        end
        4: rgn = rrbm_pkg::RGN_EXT_RAM;
        default: rgn = unmapped_region();
      endcase
      bus_wr({rgn, 13'($urandom)}, d);
    end else if (pick < 95) begin
      if ($urandom_range(1) == 0) rom_load({7'($urandom), rom_off[$urandom_range(3)]}, d);
      else rom_load(21'($urandom), d);
    end else begin
      send_word(rrbm_pkg::KIND_NONE, 16'($urandom), 21'($urandom), d);
    end
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    kind        = rrbm_pkg::KIND_READ;
    bus_address = '0;
    load_index  = '0;
    data_in     = '0;
    out_ready   = 1'b1;
    idle_pct    = 0;
    stall_pct   = 0;
    rom_off     = '{14'h0000, 14'h3FFF, 14'($urandom), 14'($urandom)};
    ram_off     = '{13'h0000, 13'h1FFF, 13'($urandom), 13'($urandom)};
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // seed the read-back offsets of every ROM bank
    for (int b = 0; b < rrbm_pkg::ROM_BANKS_DEF; b++)
      for (int i = 0; i < 4; i++) rom_load({7'(b), rom_off[i]}, 8'($urandom));

    // and of every RAM bank, through RAM mode
    bus_wr({rrbm_pkg::RGN_CTL_MODE, 13'd0}, 8'h01);
    for (int b = 0; b < rrbm_pkg::RAM_BANKS_DEF; b++) begin
      bus_wr({rrbm_pkg::RGN_CTL_BANK_HI, 13'd0}, 8'(b));
      for (int i = 0; i < 4; i++)
        bus_wr({rrbm_pkg::RGN_EXT_RAM, ram_off[i]}, 8'($urandom));
    end
    bus_wr({rrbm_pkg::RGN_CTL_MODE, 13'd0}, 8'h00);

    // decode corners: bank 0 ends, zero bank fix-up, top ROM bank, unmapped
    // space, RAM disabled, mode switch, no-op kind, highest load index
    bus_rd(16'h0000);
    bus_rd(16'h3FFF);
    bus_rd({2'b01, rom_off[0]});
    bus_wr({rrbm_pkg::RGN_CTL_ROM_LO, 13'd0}, 8'h00);
    bus_rd({2'b01, rom_off[1]});
    bus_wr({rrbm_pkg::RGN_CTL_ROM_LO, 13'h1FFF}, 8'hFF);
    bus_wr({rrbm_pkg::RGN_CTL_BANK_HI, 13'h1FFF}, 8'h03);
    bus_rd({2'b01, rom_off[2]});
    bus_wr({rrbm_pkg::RGN_CTL_ROM_LO, 13'd0}, 8'hE0);
    bus_rd({2'b01, rom_off[3]});
    bus_rd({rrbm_pkg::RGN_UNMAP_LO, 13'd0});
    bus_rd({rrbm_pkg::RGN_UNMAP_LO, 13'h1FFF});
    bus_rd({rrbm_pkg::RGN_UNMAP_HI0, 13'd0});
    bus_rd({rrbm_pkg::RGN_UNMAP_HI1, 13'h1FFF});
    bus_wr({rrbm_pkg::RGN_UNMAP_LO, 13'd0}, 8'h55);
    bus_wr({rrbm_pkg::RGN_UNMAP_HI1, 13'h1FFF}, 8'hAA);
    bus_rd({rrbm_pkg::RGN_EXT_RAM, ram_off[0]});
    bus_wr({rrbm_pkg::RGN_CTL_ENABLE, 13'd0}, 8'h0A);
    bus_rd({rrbm_pkg::RGN_EXT_RAM, ram_off[1]});
    bus_wr({rrbm_pkg::RGN_CTL_MODE, 13'd0}, 8'h80);
    bus_wr({rrbm_pkg::RGN_CTL_BANK_HI, 13'd0}, 8'hFE);
    bus_rd({rrbm_pkg::RGN_EXT_RAM, ram_off[2]});
    bus_wr({rrbm_pkg::RGN_CTL_ENABLE, 13'h1FFF}, 8'h1B);
    bus_rd({rrbm_pkg::RGN_EXT_RAM, ram_off[0]});
    send_word(rrbm_pkg::KIND_NONE, {rrbm_pkg::RGN_EXT_RAM, ram_off[0]}, 21'h1FFFFF, 8'h0A);
    rom_load(21'h1FFFFF, 8'hFF);
    drain_reads();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 47; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 47; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      repeat (WORDS_PER_PHASE) random_word();
      drain_reads();
    end

    stall_pct = 0;
    repeat (10) @(negedge clk);

    $display("covered %0d reads (%0d bytes compared), %0d bus writes, %0d ROM loads, %0d no-ops",
             n_reads, bytes_checked, n_writes, n_loads, n_noops);
    $display("traffic mixes: free flow, sender idle 47%%, receiver stall 47%%, both 37%%");
    if (mismatches == 0 && pending_reads == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/rrbm_pkg.sv
src/rrbm_ctrl.sv
src/rrbm_datapath.sv
src/rom_ram_bank_switch_mapper_top.sv
tb/rrbm_bank_checker.sv
tb/rom_ram_bank_switch_mapper_top_test.sv
